// File: hdl/nktl_pkg.sv
// ============================================================================
// nktl_pkg - shared constants and codes for the nearest key table lookup
// Table geometry, field widths, command and status codes, register map.
// ============================================================================
package nktl_pkg;

  // table geometry
  localparam int FEATURES = 16;
  localparam int ENTRIES  = 256;
  localparam int DEPTH    = FEATURES * ENTRIES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int FIDX_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  // request and result fields
  localparam int CMD_W  = 2;
  localparam int FEAT_W = 4;
  localparam int KEY_W  = 64;
  localparam int STAT_W = 2;

  localparam logic [KEY_W-1:0] SIGN_BIT  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] MINUS_ONE = '1;

  // register port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MAP_EN = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NEAR   = 2'd1,
    ST_MISS   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

endpackage

// File: hdl/nktl_ram.sv
// ============================================================================
// nktl_ram - generic single write, single read RAM
// One write port, one read port, read data registered.
// ============================================================================
module nktl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/nearest_key_table_lookup_core.sv
// ============================================================================
// nearest_key_table_lookup_core - sorted key tables with nearest-key lookup
// Per-feature sorted (key, value) tables held in RAM, searched by a
// one-probe-per-cycle binary search sequencer.
// ============================================================================
// Handles one request at a time; in_stall is high from acceptance until the
// result has been placed in the output register, so a new request may enter
// while the previous result still waits on out_stall. Clear, the unused
// command, loads to a full table and queries that need no table access
// (lookups switched off, or an empty table) go straight from S_IDLE to
// S_RESP; any other load passes through S_LDCHK first (one key read to check
// ordering). A query of a table holding n entries makes p probes in S_SRCH,
// p at most ceil(log2(n+1)), then enters S_FIN; an exact hit goes on to
// S_VAL, a nearest hit through S_DIFF, S_PICK and S_VAL, a plain miss
// straight to S_RESP. The search loop is bound by the key RAM read port, one
// probe per cycle. S_RESP waits while the output register still holds an
// earlier result under out_stall. Keys are stored biased (sign bit flipped)
// so that unsigned compares order them. No clearing pass is needed after
// reset: the per-feature entry counts (flops) bound every read to written
// entries.
// ============================================================================
module nearest_key_table_lookup_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [nktl_pkg::CMD_W-1:0]            in_cmd,
  input  logic [nktl_pkg::FEAT_W-1:0]           in_feature_index,
  input  logic signed [nktl_pkg::KEY_W-1:0]     in_lookup_key,
  input  logic signed [nktl_pkg::KEY_W-1:0]     in_load_value,
  input  logic                                  in_nearest_mode,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [nktl_pkg::STAT_W-1:0]           out_status,
  output logic signed [nktl_pkg::KEY_W-1:0]     out_result_value,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [nktl_pkg::PADDR_W-1:0]          paddr,
  input  logic [nktl_pkg::PDATA_W-1:0]          pwdata,
  output logic [nktl_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  localparam int KW = nktl_pkg::KEY_W;
  localparam int CW = nktl_pkg::CNT_W;
  localparam int IW = nktl_pkg::IDX_W;
  localparam int AW = nktl_pkg::ADDR_W;
  localparam int FW = nktl_pkg::FIDX_W;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // waiting for a request
    S_LDCHK = 8'b0000_0010,  // last key back from RAM, ordering check
    S_SRCH  = 8'b0000_0100,  // binary search, one probe per cycle
    S_FIN   = 8'b0000_1000,  // search done, exact hit check
    S_DIFF  = 8'b0001_0000,  // distances to the two neighbours
    S_PICK  = 8'b0010_0000,  // nearer neighbour chosen, value read issued
    S_VAL   = 8'b0100_0000,  // mapped value back from RAM
    S_RESP  = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t           state_r, state_nxt;

  // control state
  logic [CW-1:0]    count_r [nktl_pkg::FEATURES];
  logic             map_en_r;
  logic             out_valid_r;
  logic             pend_r;

  // request payload and search registers
  logic [FW-1:0]    fsel_r;
  logic [KW-1:0]    key_r;
  logic [KW-1:0]    lval_r;
  logic             near_r;
  logic [CW-1:0]    n_r;
  logic [CW-1:0]    lo_r;
  logic [CW-1:0]    hi_r;
  logic [CW-1:0]    mid_r;
  logic [KW-1:0]    lo_key_r;
  logic [KW-1:0]    hi_key_r;
  logic [KW-1:0]    below_r;
  logic [KW-1:0]    above_r;
  logic [nktl_pkg::STAT_W-1:0] res_status_r;
  logic [KW-1:0]    res_value_r;
  logic [nktl_pkg::STAT_W-1:0] out_status_r;
  logic [KW-1:0]    out_value_r;

  // combinational
  logic             in_acc;
  logic             out_acc;
  logic             cfg_wr;
  logic             feat_ok_in;
  logic [FW-1:0]    fsel_in;
  logic [CW-1:0]    n_in;
  logic [FW-1:0]    rd_feat;
  logic [IW-1:0]    rd_idx;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic [KW-1:0]    key_rd;
  logic [KW-1:0]    map_rd;
  logic             lt;
  logic [CW-1:0]    lo_c;
  logic [CW-1:0]    hi_c;
  logic [CW-1:0]    mid_c;
  logic             go_on;
  logic             ld_ok;
  logic             exact;
  logic [IW-1:0]    pick_c;

  // --------------------------------------------------------------------------
  // handshakes and register port
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_acc  = out_valid_r && !out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[nktl_pkg::PADDR_W-1:2] == nktl_pkg::REG_MAP_EN);
  assign prdata = (paddr[nktl_pkg::PADDR_W-1:2] == nktl_pkg::REG_MAP_EN)
                  ? {{(nktl_pkg::PDATA_W-1){1'b0}}, map_en_r} : '0;

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  assign feat_ok_in = (int'(in_feature_index) < nktl_pkg::FEATURES);
  assign fsel_in    = FW'(in_feature_index);
  assign n_in       = count_r[fsel_in];

  // --------------------------------------------------------------------------
  // search step: fold in the last probe, then pick the next midpoint
  // --------------------------------------------------------------------------
  assign lt = (key_rd < key_r);

  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (pend_r) begin
      if (lt) begin
        lo_c = CW'(mid_r + 1'b1);
      end else begin
        hi_c = mid_r;
      end
    end
  end

  assign mid_c = CW'(lo_c + ((hi_c - lo_c) >> 1));
  assign go_on = (lo_c < hi_c);

  // load ordering: first entry always fits, else key must exceed the last
  assign ld_ok = (n_r == '0) || (key_r > key_rd);

  // lower bound is lo_r; hi_key_r holds the key there when lo_r < n
  assign exact = (lo_r != n_r) && (hi_key_r == key_r);

  // nearer neighbour, ties to the smaller key
  always_comb begin
    if (lo_r == '0) begin
      pick_c = '0;
    end else if (lo_r == n_r) begin
      pick_c = IW'(n_r - 1'b1);
    end else if (above_r < below_r) begin
      pick_c = IW'(lo_r);
    end else begin
      pick_c = IW'(lo_r - 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // RAM addressing; both stores share one read address
  // --------------------------------------------------------------------------
  always_comb begin
    rd_feat = fsel_r;
    rd_idx  = '0;
    case (state_r)
      S_IDLE: begin
        rd_feat = fsel_in;
        rd_idx  = (n_in == '0) ? '0 : IW'(n_in - 1'b1);
      end
      S_SRCH: begin
        rd_idx = IW'(mid_c);
      end
      S_FIN: begin
        rd_idx = IW'(lo_r);
      end
      S_PICK: begin
        rd_idx = pick_c;
      end
      default: begin
        rd_idx = '0;
      end
    endcase
  end

  assign rd_addr = AW'(rd_feat) * AW'(nktl_pkg::ENTRIES) + AW'(rd_idx);
  assign wr_addr = AW'(fsel_r) * AW'(nktl_pkg::ENTRIES) + AW'(IW'(n_r));
  assign wr_en   = (state_r == S_LDCHK) && ld_ok;

  nktl_ram #(
    .WIDTH (KW),
    .DEPTH (nktl_pkg::DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  nktl_ram #(
    .WIDTH (KW),
    .DEPTH (nktl_pkg::DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (lval_r),
    .raddr (rd_addr),
    .rdata (map_rd)
  );

  // --------------------------------------------------------------------------
  // sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RESP;
          if (in_cmd == nktl_pkg::CMD_LOAD) begin
            if (feat_ok_in && (n_in != CW'(nktl_pkg::ENTRIES))) begin
              state_nxt = S_LDCHK;
            end
          end else if (in_cmd == nktl_pkg::CMD_QUERY) begin
            if (map_en_r && feat_ok_in && (n_in != '0)) begin
              state_nxt = S_SRCH;
            end
          end
        end
      end
      S_LDCHK: state_nxt = S_RESP;
      S_SRCH: begin
        if (!go_on) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (exact) begin
          state_nxt = S_VAL;
        end else if (near_r) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DIFF: state_nxt = S_PICK;
      S_PICK: state_nxt = S_VAL;
      S_VAL:  state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int i = 0; i < nktl_pkg::FEATURES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        map_en_r <= pwdata[0];
      end

      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_RESP) && (state_nxt == S_IDLE)) begin
        out_valid_r <= 1'b1;
      end

      // probe in flight flag for the search loop
      if (state_r == S_SRCH) begin
        pend_r <= go_on;
      end else begin
        pend_r <= 1'b0;
      end

      if (in_acc && (in_cmd == nktl_pkg::CMD_CLEAR)) begin
        for (int i = 0; i < nktl_pkg::FEATURES; i++) begin
          count_r[i] <= '0;
        end
      end
      if (wr_en) begin
        count_r[fsel_r] <= CW'(n_r + 1'b1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fsel_r       <= fsel_in;
          key_r        <= in_lookup_key ^ nktl_pkg::SIGN_BIT;
          lval_r       <= in_load_value;
          near_r       <= in_nearest_mode;
          n_r          <= n_in;
          lo_r         <= '0;
          hi_r         <= n_in;
          res_value_r  <= nktl_pkg::MINUS_ONE;
          case (in_cmd)
            nktl_pkg::CMD_CLEAR: res_status_r <= nktl_pkg::ST_OK;
            nktl_pkg::CMD_LOAD:  res_status_r <= nktl_pkg::ST_REJECT;
            default:             res_status_r <= nktl_pkg::ST_MISS;
          endcase
        end
      end
      S_LDCHK: begin
        res_status_r <= ld_ok ? nktl_pkg::ST_OK : nktl_pkg::ST_REJECT;
      end
      S_SRCH: begin
        lo_r <= lo_c;
        hi_r <= hi_c;
        if (go_on) begin
          mid_r <= mid_c;
        end
        if (pend_r) begin
          if (lt) begin
            lo_key_r <= key_rd;
          end else begin
            hi_key_r <= key_rd;
          end
        end
      end
      S_FIN: begin
        if (exact) begin
          res_status_r <= nktl_pkg::ST_OK;
        end
      end
      S_DIFF: begin
        below_r <= key_r - lo_key_r;
        above_r <= hi_key_r - key_r;
      end
      S_PICK: begin
        res_status_r <= nktl_pkg::ST_NEAR;
      end
      S_VAL: begin
        res_value_r <= map_rd;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_status_r <= res_status_r;
          out_value_r  <= res_value_r;
        end
      end
      default: begin
        res_value_r <= res_value_r;
      end
    endcase
  end

`ifndef SYNTH
  // search window never widens past the table fill
  a_srch_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((lo_r <= hi_r) && (hi_r <= n_r)))
    else $error("search window out of range");

  // a load only reaches the ordering check with room left in the table
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDCHK) |-> (n_r < CW'(nktl_pkg::ENTRIES)))
    else $error("load check on a full table");

  // value fetch only follows an exact hit or a nearest pick
  a_val_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VAL) |-> ($past(state_r) == S_FIN || $past(state_r) == S_PICK))
    else $error("value fetch without a search result");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench - nearest key table lookup core
// Drives clear, load and query requests into the core, predicts every result
// from its own copy of the sorted tables and checks each one as it leaves.
// ============================================================================
module testbench;

  localparam int FEATURES  = nktl_pkg::FEATURES;
  localparam int ENTRIES   = nktl_pkg::ENTRIES;
  localparam int CMD_W     = nktl_pkg::CMD_W;
  localparam int FEAT_W    = nktl_pkg::FEAT_W;
  localparam int KEY_W     = nktl_pkg::KEY_W;
  localparam int STAT_W    = nktl_pkg::STAT_W;
  localparam int PADDR_W   = nktl_pkg::PADDR_W;
  localparam int PDATA_W   = nktl_pkg::PDATA_W;
  localparam int REG_IDX_W = nktl_pkg::REG_IDX_W;

  localparam logic [KEY_W-1:0] SIGN_BIT  = nktl_pkg::SIGN_BIT;
  localparam logic [KEY_W-1:0] MINUS_ONE = nktl_pkg::MINUS_ONE;
  localparam logic [KEY_W-1:0] KEY_MIN   = SIGN_BIT;
  localparam logic [KEY_W-1:0] KEY_MAX   = ~SIGN_BIT;

  typedef struct packed {
    nktl_pkg::status_t status;
    logic [KEY_W-1:0]  value;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the tables (keys biased so unsigned order is
  // signed order), the enable register and the answers still owed.
  // --------------------------------------------------------------------------
  class lookup_scoreboard;
    logic [KEY_W-1:0] key_tab [FEATURES][ENTRIES];
    logic [KEY_W-1:0] val_tab [FEATURES][ENTRIES];
    int unsigned      fill [FEATURES];
    bit               map_en;
    answer_t          answers_due [$];
    int unsigned      fails;
    int unsigned      seen;

    function new();
      foreach (fill[i]) fill[i] = 0;
      map_en = 1'b0;
      fails  = 0;
      seen   = 0;
    endfunction

    task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
      $display("MISMATCH result %0d: %s got %h want %h", seen, what, got, want);
      fails++;
    endtask

    function void configure(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
      if (idx == nktl_pkg::REG_MAP_EN) map_en = data[0];
    endfunction

    function int unsigned outstanding();
      return answers_due.size();
    endfunction

    // what the core must answer to one request; updates the tables
    function answer_t lookup_outcome(nktl_pkg::cmd_t cmd, logic [FEAT_W-1:0] feat,
                                     logic [KEY_W-1:0] key, logic [KEY_W-1:0] lval,
                                     bit nearest);
      answer_t          ans;
      logic [KEY_W-1:0] q;
      logic [KEY_W-1:0] dist_lo;
      logic [KEY_W-1:0] dist_hi;
      int unsigned      n;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      int unsigned      pick;
      ans.status = nktl_pkg::ST_MISS;
      ans.value  = MINUS_ONE;
      q = key ^ SIGN_BIT;
      n = fill[feat];
      case (cmd)
        nktl_pkg::CMD_CLEAR: begin
          foreach (fill[i]) fill[i] = 0;
          ans.status = nktl_pkg::ST_OK;
        end
        nktl_pkg::CMD_LOAD: begin
          ans.status = nktl_pkg::ST_REJECT;
          if (n < ENTRIES && (n == 0 || q > key_tab[feat][n-1])) begin
            key_tab[feat][n] = q;
            val_tab[feat][n] = lval;
            fill[feat] = n + 1;
            ans.status = nktl_pkg::ST_OK;
          end
        end
        nktl_pkg::CMD_QUERY: begin
          if (map_en && n != 0) begin
            // first slot whose key is not below the query
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (key_tab[feat][mid] < q) lo = mid + 1;
              else hi = mid;
            end
            if (lo < n && key_tab[feat][lo] == q) begin
              ans.status = nktl_pkg::ST_OK;
              ans.value  = val_tab[feat][lo];
            end else if (nearest) begin
              if (lo == 0) begin
                pick = 0;
              end else if (lo == n) begin
                pick = n - 1;
              end else begin
                // unsigned distances; a tie goes to the smaller key
                dist_lo = q - key_tab[feat][lo-1];
                dist_hi = key_tab[feat][lo] - q;
                pick = (dist_hi < dist_lo) ? lo : lo - 1;
              end
              ans.status = nktl_pkg::ST_NEAR;
              ans.value  = val_tab[feat][pick];
            end
          end
        end
        default: ;
      endcase
      return ans;
    endfunction

    function void note_request(nktl_pkg::cmd_t cmd, logic [FEAT_W-1:0] feat,
                               logic [KEY_W-1:0] key, logic [KEY_W-1:0] lval,
                               bit nearest);
      answer_t ans;
      ans = lookup_outcome(cmd, feat, key, lval, nearest);
      answers_due = {answers_due, ans};
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic [KEY_W-1:0] val);
      answer_t want;
      seen++;
      if (answers_due.size() == 0) begin
        report_mismatch("result with no request waiting", KEY_W'(st), '0);
        return;
      end
      want = answers_due.pop_front();
      if (st !== want.status) report_mismatch("status", KEY_W'(st), KEY_W'(want.status));
      if (val !== want.value) report_mismatch("result_value", val, want.value);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and shared signals
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [FEAT_W-1:0]   in_feature_index;
  logic [KEY_W-1:0]    in_lookup_key;
  logic [KEY_W-1:0]    in_load_value;
  logic                in_nearest_mode;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   out_status;
  logic [KEY_W-1:0]    out_result_value;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  lookup_scoreboard    sb;
  bit                  idle_ok;     // both sides may idle at random
  int                  hold_off;    // receiver stall cycles still to run
  logic [FEAT_W-1:0]   focus_feat;  // feature most requests go to this phase

  // stimulus-side view of what each table holds (biased keys), used only to
  // aim loads and queries at interesting keys
  logic [KEY_W-1:0]    stim_key [FEATURES][ENTRIES];
  int unsigned         stim_fill [FEATURES];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  nearest_key_table_lookup_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_feature_index (in_feature_index),
    .in_lookup_key    (in_lookup_key),
    .in_load_value    (in_load_value),
    .in_nearest_mode  (in_nearest_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Both handshakes sampled at the edge; inputs only change via NBAs, so the
  // values seen here are the ones the core saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(nktl_pkg::cmd_t'(in_cmd), in_feature_index, in_lookup_key,
                      in_load_value, in_nearest_mode);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_result_value);
  end

  // Receiver: random stalls, or a long hold-off counted down here so that
  // the core fills up and pushes back on the request side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off = hold_off - 1;
    end else begin
      out_stall <= idle_ok && ($urandom_range(0, 99) < 23);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void shadow_apply(nktl_pkg::cmd_t c, logic [FEAT_W-1:0] f,
                                       logic [KEY_W-1:0] bkey);
    int unsigned n;
    n = stim_fill[f];
    if (c == nktl_pkg::CMD_CLEAR) begin
      foreach (stim_fill[i]) stim_fill[i] = 0;
    end else if (c == nktl_pkg::CMD_LOAD && n < ENTRIES
                 && (n == 0 || bkey > stim_key[f][n-1])) begin
      stim_key[f][n] = bkey;
      stim_fill[f] = n + 1;
    end
  endfunction

  // Offers one request and returns once it has been taken. in_valid stays
  // high afterwards unless the next call idles or the caller drains.
  task automatic send_request(nktl_pkg::cmd_t c, logic [FEAT_W-1:0] f,
                              logic [KEY_W-1:0] k, logic [KEY_W-1:0] v, bit nm);
    while (idle_ok && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    shadow_apply(c, f, k ^ SIGN_BIT);
    in_valid         <= 1'b1;
    in_cmd           <= c;
    in_feature_index <= f;
    in_lookup_key    <= k;
    in_load_value    <= v;
    in_nearest_mode  <= nm;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause: nothing offered until every answer owed has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.configure(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [FEAT_W-1:0] pick_feature();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return focus_feat;
    if (r < 75) return FEAT_W'($urandom_range(0, 3));
    return FEAT_W'($urandom_range(0, FEATURES - 1));
  endfunction

  // Next biased key for an ordered load; an overflowing step repeats the last
  // key so that the load is turned away. 'fine' keeps steps tiny.
  function automatic logic [KEY_W-1:0] fresh_key(logic [FEAT_W-1:0] f, bit fine);
    int unsigned      n;
    logic [KEY_W-1:0] last;
    logic [KEY_W-1:0] step;
    n = stim_fill[f];
    if (n == 0) begin
      if (fine) return rand64() >> 4;
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return rand64();
        default: return rand64() >> $urandom_range(2, 12);
      endcase
    end
    last = stim_key[f][n-1];
    if (!fine && $urandom_range(0, 39) == 0) return MINUS_ONE;
    if (fine || $urandom_range(0, 1) == 1) step = KEY_W'($urandom_range(1, 4));
    else step = (rand64() >> $urandom_range(8, 63)) + 1;
    if (step > ~last) return last;
    return last + step;
  endfunction

  // Biased query key: hits, midpoints (ties), neighbours, beyond either end,
  // anywhere, and the two extremes.
  function automatic logic [KEY_W-1:0] query_key(logic [FEAT_W-1:0] f);
    int unsigned      n;
    int unsigned      i;
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] d;
    n = stim_fill[f];
    if (n == 0) return rand64();
    d = KEY_W'($urandom_range(1, 3));
    i = $urandom_range(0, n - 1);
    a = stim_key[f][i];
    b = (i + 1 < n) ? stim_key[f][i+1] : a;
    case ($urandom_range(0, 7))
      0, 1:    return a;
      2:       return a + ((b - a) >> 1) + KEY_W'($urandom_range(0, 1));
      3:       return ($urandom_range(0, 1) == 1) ? a + 1 : a - 1;
      4:       return (stim_key[f][0] > d) ? stim_key[f][0] - d : '0;
      5:       return (stim_key[f][n-1] < ~d) ? stim_key[f][n-1] + d : MINUS_ONE;
      6:       return rand64();
      default: return ($urandom_range(0, 1) == 1) ? MINUS_ONE : '0;
    endcase
  endfunction

  // Mostly ordered loads and aimed queries; the rest clears, stray loads and
  // the unused command.
  task automatic random_request();
    int unsigned      r;
    logic [FEAT_W-1:0] f;
    logic [FEAT_W-1:0] any_f;
    r = $urandom_range(0, 199);
    f = pick_feature();
    any_f = FEAT_W'($urandom_range(0, FEATURES - 1));
    if (r < 2)
      send_request(nktl_pkg::CMD_CLEAR, any_f, rand64(), rand64(),
                   1'($urandom_range(0, 1)));
    else if (r < 80)
      send_request(nktl_pkg::CMD_LOAD, f, fresh_key(f, 1'b0) ^ SIGN_BIT, rand64(),
                   1'($urandom_range(0, 1)));
    else if (r < 90)
      send_request(nktl_pkg::CMD_LOAD, any_f, rand64(), rand64(),
                   1'($urandom_range(0, 1)));
    else if (r < 96)
      send_request(nktl_pkg::CMD_RSVD, any_f, rand64(), rand64(),
                   1'($urandom_range(0, 1)));
    else
      send_request(nktl_pkg::CMD_QUERY, f, query_key(f) ^ SIGN_BIT, rand64(),
                   1'($urandom_range(0, 3) != 0));
    if (r >= 96 || r < 80) begin
      // queries are the point: after a clear, ordered load or query, one more aimed query follows half the time
      if ($urandom_range(0, 1) == 1)
        send_request(nktl_pkg::CMD_QUERY, f, query_key(f) ^ SIGN_BIT, rand64(),
                     1'($urandom_range(0, 3) != 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = nktl_pkg::CMD_CLEAR;
    in_feature_index = '0;
    in_lookup_key    = '0;
    in_load_value    = '0;
    in_nearest_mode  = 1'b0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    idle_ok          = 1'b1;
    hold_off         = 0;
    focus_feat       = '0;
    foreach (stim_fill[i]) stim_fill[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lookups switched off after reset: queries miss, loads still land
    send_request(nktl_pkg::CMD_QUERY, 4'd0, 64'd0, 64'd0, 1'b1);
    send_request(nktl_pkg::CMD_LOAD, 4'd0, KEY_MIN, KEY_MAX, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd0, KEY_MIN, 64'd1, 1'b0);  // equal key, turned away
    send_request(nktl_pkg::CMD_LOAD, 4'd0, -64'sd5, 64'd0, 1'b0);
    send_request(nktl_pkg::CMD_QUERY, 4'd0, KEY_MIN, 64'd0, 1'b1);
    send_request(nktl_pkg::CMD_RSVD, 4'd3, 64'd7, 64'd7, 1'b1);
    drain();
    write_register(nktl_pkg::REG_MAP_EN, 32'd1);

    send_request(nktl_pkg::CMD_LOAD, 4'd0, 64'sd10, KEY_MIN, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd0, 64'sd20, MINUS_ONE, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd0, 64'sd15, 64'd3, 1'b0);    // out of order
    send_request(nktl_pkg::CMD_LOAD, 4'd0, KEY_MAX, 64'd123, 1'b0);
    send_request(nktl_pkg::CMD_QUERY, 4'd0, 64'sd10, 64'd0, 1'b0);   // exact hit
    send_request(nktl_pkg::CMD_QUERY, 4'd0, 64'sd11, 64'd0, 1'b0);   // plain miss
    send_request(nktl_pkg::CMD_QUERY, 4'd0, 64'sd15, 64'd0, 1'b1);   // tie, smaller key wins
    send_request(nktl_pkg::CMD_QUERY, 4'd0, KEY_MIN, 64'd0, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd1, 64'sd100, 64'd55, 1'b0);
    send_request(nktl_pkg::CMD_QUERY, 4'd1, KEY_MIN, 64'd0, 1'b1);   // below the first key
    send_request(nktl_pkg::CMD_QUERY, 4'd1, KEY_MAX, 64'd0, 1'b1);   // above the last key
    // only the two extreme keys stored: distances straddle 2^63
    send_request(nktl_pkg::CMD_LOAD, 4'd2, KEY_MIN, 64'd1, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd2, KEY_MAX, 64'd2, 1'b0);
    send_request(nktl_pkg::CMD_QUERY, 4'd2, 64'd0, 64'd0, 1'b1);
    send_request(nktl_pkg::CMD_QUERY, 4'd2, MINUS_ONE, 64'd0, 1'b1);
    send_request(nktl_pkg::CMD_QUERY, 4'd15, 64'd0, 64'd0, 1'b1);    // empty table
    send_request(nktl_pkg::CMD_CLEAR, 4'd0, 64'd0, 64'd0, 1'b0);
    send_request(nktl_pkg::CMD_LOAD, 4'd15, MINUS_ONE, 64'd9, 1'b0);
    send_request(nktl_pkg::CMD_QUERY, 4'd15, MINUS_ONE, 64'd0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_register(nktl_pkg::REG_MAP_EN, (phase == 2) ? 32'd0 : 32'd1);
      idle_ok    = (phase != 4);   // one phase with no idling on either side
      focus_feat = FEAT_W'(phase * 5 + 1);
      if (phase == 1) hold_off = 300;
      if (phase == 3) begin
        // fill one table to the brim, a few loads past full
        focus_feat = 4'd9;
        send_request(nktl_pkg::CMD_CLEAR, 4'd9, 64'd0, 64'd0, 1'b0);
        repeat (ENTRIES + 4)
          send_request(nktl_pkg::CMD_LOAD, 4'd9, fresh_key(4'd9, 1'b1) ^ SIGN_BIT,
                       rand64(), 1'b0);
      end
      repeat (145) random_request();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("nearest_key_table_lookup_core verification clean");
    end else begin
      $display("nearest_key_table_lookup_core verification failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("nearest_key_table_lookup_core verification failed");
    $finish;
  end

endmodule
